[rtl/core/brs_pkg.sv]
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants for the biquadratic root solver.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int CW = 32;
  localparam int RW = 41;
  localparam int SK = 33;
  localparam int QW = 49;

  localparam logic [1:0] ST_INF   = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_ROOTS = 2'd2;

  typedef enum logic [1:0] {
    KIND_INF,
    KIND_NONE,
    KIND_LIN,
    KIND_QUAD
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [CW-1:0]  b;
    logic           a_neg;
    logic [CW-1:0]  mag_a;
    logic [CW-1:0]  mag_b;
    logic [CW-1:0]  mag_c;
    logic           lin_ok;
  } ctl_t;

  typedef struct packed {
    kind_t kind;
    logic  ok1;
  } lane1_t;

  typedef struct packed {
    logic ok2;
    logic eq;
  } lane2_t;

endpackage

[rtl/core/biquadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// biquadratic_root_solver
// Real roots of a*x^4 + b*x^2 + c = 0 through a chain of digit cells.
//
//   channel  dir  width  fields (lowest bit first)
//   s_axis   in   96     coef_quartic, coef_square, coef_constant
//   m_axis   out  176    solve_status, root_count, root_0..root_3, zero pad
//
// One beat is accepted per cycle while the output register is empty or being
// taken; then all stages move together: input, stage 1 and 2 registers, the
// discriminant root cells, a numerator register, the quotient cells, the root
// cells and the output register. An empty input register still takes a beat
// while the pipe is stalled. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module biquadratic_root_solver (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // coef_quartic, coef_square, coef_constant
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // solve_status, root_count, root_0, root_1, root_2, root_3, zero pad
  output logic [175:0] m_tdata
);
  import brs_pkg::*;

  localparam int CPW = $bits(ctl_t);
  localparam int L1W = $bits(lane1_t);
  localparam int L2W = $bits(lane2_t);

  logic adv;

  logic          s0_v;
  logic [CW-1:0] s0_a, s0_b, s0_c;

  logic          s1_v;
  ctl_t          s1_ctl;
  logic [63:0]   s1_q, s1_p;
  logic          s1_ac_pos;

  logic          s2_v;
  ctl_t          s2_ctl;
  logic [65:0]   s2_delta;

  logic          out_v;
  logic [1:0]    out_status;
  logic [2:0]    out_count;
  logic [RW-1:0] out_r0, out_r1, out_r2, out_r3;

  assign adv      = !out_v || m_tready;
  assign s_tready = !s0_v || adv;
  assign m_tvalid = out_v;
  assign m_tdata  = {7'd0, out_r3, out_r2, out_r1, out_r0, out_count, out_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s_tready) begin
      s0_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s0_a <= s_tdata[31:0];
      s0_b <= s_tdata[63:32];
      s0_c <= s_tdata[95:64];
    end
  end

  // Stage 1: magnitudes, case class and the two products.
  logic [CW-1:0] mag_a, mag_b, mag_c;
  logic          za, zb, zc;
  ctl_t          ctl1;

  assign mag_a = s0_a[CW-1] ? (~s0_a + 32'd1) : s0_a;
  assign mag_b = s0_b[CW-1] ? (~s0_b + 32'd1) : s0_b;
  assign mag_c = s0_c[CW-1] ? (~s0_c + 32'd1) : s0_c;
  assign za    = (s0_a == '0);
  assign zb    = (s0_b == '0);
  assign zc    = (s0_c == '0);

  always_comb begin
    ctl1.b      = s0_b;
    ctl1.a_neg  = s0_a[CW-1];
    ctl1.mag_a  = mag_a;
    ctl1.mag_b  = mag_b;
    ctl1.mag_c  = mag_c;
    ctl1.lin_ok = zc || (s0_c[CW-1] != s0_b[CW-1]);
    if (za && zb && zc) begin
      ctl1.kind = KIND_INF;
    end else if (za && zb) begin
      ctl1.kind = KIND_NONE;
    end else if (za) begin
      ctl1.kind = KIND_LIN;
    end else begin
      ctl1.kind = KIND_QUAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl    <= ctl1;
      s1_q      <= mag_b * mag_b;
      s1_p      <= mag_a * mag_c;
      s1_ac_pos <= !zc && (s0_a[CW-1] == s0_c[CW-1]);
    end
  end

  // Stage 2: discriminant and its sign.
  logic  disc_neg;
  ctl_t  ctl2;

  assign disc_neg = s1_ac_pos && (s1_p > {2'b00, s1_q[63:2]});

  always_comb begin
    ctl2 = s1_ctl;
    if (s1_ctl.kind == KIND_QUAD && disc_neg) begin
      ctl2.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl   <= ctl2;
      s2_delta <= s1_ac_pos ? ({2'b00, s1_q} - {s1_p, 2'b00})
                            : ({2'b00, s1_q} + {s1_p, 2'b00});
    end
  end

  // Square root of the discriminant.
  logic            sa_v    [0:SK];
  logic [2*SK-1:0] sa_rad  [0:SK];
  logic [SK+1:0]   sa_rem  [0:SK];
  logic [SK-1:0]   sa_root [0:SK];
  logic [CPW-1:0]  sa_pay  [0:SK];

  assign sa_v[0]    = s2_v;
  assign sa_rad[0]  = s2_delta;
  assign sa_rem[0]  = '0;
  assign sa_root[0] = '0;
  assign sa_pay[0]  = s2_ctl;

  for (genvar i = 0; i < SK; i++) begin : g_sa
    brs_sqrt_cell #(.K(SK), .PW(CPW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(sa_v[i]), .in_rad(sa_rad[i]), .in_rem(sa_rem[i]),
      .in_root(sa_root[i]), .in_pay(sa_pay[i]),
      .out_valid(sa_v[i+1]), .out_rad(sa_rad[i+1]), .out_rem(sa_rem[i+1]),
      .out_root(sa_root[i+1]), .out_pay(sa_pay[i+1])
    );
  end

  // Numerators of the two quotients.
  ctl_t          ctl3;
  logic [34:0]   nb, n1, n2;
  logic [33:0]   mag1, mag2;
  logic          okq1, okq2;
  logic          n_v;
  logic [QW-1:0] n_d1, n_d2;
  logic [CW-1:0] n_dv1, n_dv2;
  lane1_t        n_l1;
  logic          n_ok2;

  assign ctl3 = ctl_t'(sa_pay[SK]);
  assign nb   = ~{{3{ctl3.b[CW-1]}}, ctl3.b} + 35'd1;
  assign n1   = nb + {2'b00, sa_root[SK]};
  assign n2   = nb - {2'b00, sa_root[SK]};
  assign mag1 = n1[34] ? 34'(~n1 + 35'd1) : n1[33:0];
  assign mag2 = n2[34] ? 34'(~n2 + 35'd1) : n2[33:0];
  assign okq1 = (n1 == '0) || (n1[34] == ctl3.a_neg);
  assign okq2 = (n2 == '0) || (n2[34] == ctl3.a_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (adv) begin
      n_v <= sa_v[SK];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_l1.kind <= ctl3.kind;
      case (ctl3.kind)
        KIND_QUAD: begin
          n_d1     <= {mag1, 15'd0};
          n_d2     <= {mag2, 15'd0};
          n_dv1    <= ctl3.mag_a;
          n_dv2    <= ctl3.mag_a;
          n_l1.ok1 <= okq1;
          n_ok2    <= okq2;
        end
        KIND_LIN: begin
          n_d1     <= {1'b0, ctl3.mag_c, 16'd0};
          n_d2     <= {1'b0, ctl3.mag_c, 16'd0};
          n_dv1    <= ctl3.mag_b;
          n_dv2    <= ctl3.mag_b;
          n_l1.ok1 <= ctl3.lin_ok;
          n_ok2    <= 1'b0;
        end
        default: begin
          n_d1     <= {mag1, 15'd0};
          n_d2     <= {mag2, 15'd0};
          n_dv1    <= ctl3.mag_a;
          n_dv2    <= ctl3.mag_a;
          n_l1.ok1 <= 1'b0;
          n_ok2    <= 1'b0;
        end
      endcase
    end
  end

  // Two quotient lanes.
  logic           da_v   [0:QW];
  logic [QW-1:0]  da_nq  [0:QW];
  logic [CW-1:0]  da_rem [0:QW];
  logic [CW-1:0]  da_div [0:QW];
  logic [L1W-1:0] da_pay [0:QW];
  logic           db_v   [0:QW];
  logic [QW-1:0]  db_nq  [0:QW];
  logic [CW-1:0]  db_rem [0:QW];
  logic [CW-1:0]  db_div [0:QW];
  logic           db_pay [0:QW];

  assign da_v[0]   = n_v;
  assign da_nq[0]  = n_d1;
  assign da_rem[0] = '0;
  assign da_div[0] = n_dv1;
  assign da_pay[0] = n_l1;
  assign db_v[0]   = n_v;
  assign db_nq[0]  = n_d2;
  assign db_rem[0] = '0;
  assign db_div[0] = n_dv2;
  assign db_pay[0] = n_ok2;

  for (genvar i = 0; i < QW; i++) begin : g_div
    brs_div_cell #(.NW(QW), .DW(CW), .PW(L1W)) u_da (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(da_v[i]), .in_nq(da_nq[i]), .in_rem(da_rem[i]),
      .in_div(da_div[i]), .in_pay(da_pay[i]),
      .out_valid(da_v[i+1]), .out_nq(da_nq[i+1]), .out_rem(da_rem[i+1]),
      .out_div(da_div[i+1]), .out_pay(da_pay[i+1])
    );
    brs_div_cell #(.NW(QW), .DW(CW), .PW(1)) u_db (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(db_v[i]), .in_nq(db_nq[i]), .in_rem(db_rem[i]),
      .in_div(db_div[i]), .in_pay(db_pay[i]),
      .out_valid(db_v[i+1]), .out_nq(db_nq[i+1]), .out_rem(db_rem[i+1]),
      .out_div(db_div[i+1]), .out_pay(db_pay[i+1])
    );
  end

  // Two root lanes.
  lane2_t          l2_in;
  logic            ra_v    [0:SK];
  logic [2*SK-1:0] ra_rad  [0:SK];
  logic [SK+1:0]   ra_rem  [0:SK];
  logic [SK-1:0]   ra_root [0:SK];
  logic [L1W-1:0]  ra_pay  [0:SK];
  logic            rb_v    [0:SK];
  logic [2*SK-1:0] rb_rad  [0:SK];
  logic [SK+1:0]   rb_rem  [0:SK];
  logic [SK-1:0]   rb_root [0:SK];
  logic [L2W-1:0]  rb_pay  [0:SK];

  assign l2_in.ok2  = db_pay[QW];
  assign l2_in.eq   = (da_nq[QW] == db_nq[QW]);
  assign ra_v[0]    = da_v[QW];
  assign ra_rad[0]  = {1'b0, da_nq[QW], 16'd0};
  assign ra_rem[0]  = '0;
  assign ra_root[0] = '0;
  assign ra_pay[0]  = da_pay[QW];
  assign rb_v[0]    = db_v[QW];
  assign rb_rad[0]  = {1'b0, db_nq[QW], 16'd0};
  assign rb_rem[0]  = '0;
  assign rb_root[0] = '0;
  assign rb_pay[0]  = l2_in;

  for (genvar i = 0; i < SK; i++) begin : g_root
    brs_sqrt_cell #(.K(SK), .PW(L1W)) u_ra (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(ra_v[i]), .in_rad(ra_rad[i]), .in_rem(ra_rem[i]),
      .in_root(ra_root[i]), .in_pay(ra_pay[i]),
      .out_valid(ra_v[i+1]), .out_rad(ra_rad[i+1]), .out_rem(ra_rem[i+1]),
      .out_root(ra_root[i+1]), .out_pay(ra_pay[i+1])
    );
    brs_sqrt_cell #(.K(SK), .PW(L2W)) u_rb (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(rb_v[i]), .in_rad(rb_rad[i]), .in_rem(rb_rem[i]),
      .in_root(rb_root[i]), .in_pay(rb_pay[i]),
      .out_valid(rb_v[i+1]), .out_rad(rb_rad[i+1]), .out_rem(rb_rem[i+1]),
      .out_root(rb_root[i+1]), .out_pay(rb_pay[i+1])
    );
  end

  // Packing of the result.
  lane1_t        fa;
  lane2_t        fb;
  logic          take1, take2;
  logic [RW-1:0] ra_pos, ra_neg, rb_pos, rb_neg;

  assign fa     = lane1_t'(ra_pay[SK]);
  assign fb     = lane2_t'(rb_pay[SK]);
  assign take1  = fa.ok1;
  assign take2  = fb.ok2 && !(fa.ok1 && fb.eq);
  assign ra_pos = {{(RW-SK){1'b0}}, ra_root[SK]};
  assign rb_pos = {{(RW-SK){1'b0}}, rb_root[SK]};
  assign ra_neg = ~ra_pos + 41'd1;
  assign rb_neg = ~rb_pos + 41'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= ra_v[SK];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case ({take1, take2})
        2'b11: begin
          out_count <= 3'd4;
          out_r0    <= ra_pos;
          out_r1    <= ra_neg;
          out_r2    <= rb_pos;
          out_r3    <= rb_neg;
        end
        2'b10: begin
          out_count <= 3'd2;
          out_r0    <= ra_pos;
          out_r1    <= ra_neg;
          out_r2    <= '0;
          out_r3    <= '0;
        end
        2'b01: begin
          out_count <= 3'd2;
          out_r0    <= rb_pos;
          out_r1    <= rb_neg;
          out_r2    <= '0;
          out_r3    <= '0;
        end
        default: begin
          out_count <= 3'd0;
          out_r0    <= '0;
          out_r1    <= '0;
          out_r2    <= '0;
          out_r3    <= '0;
        end
      endcase
      if (fa.kind == KIND_INF) begin
        out_status <= ST_INF;
      end else if (take1 || take2) begin
        out_status <= ST_ROOTS;
      end else begin
        out_status <= ST_NONE;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_count == 3'd0 || out_count == 3'd2 || out_count == 3'd4))
    else $error("root count out of range");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    out_v |-> ((out_status == ST_ROOTS) == (out_count != 3'd0)))
    else $error("status and root count disagree");

  a_pair_neg: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_count != 3'd0) |-> ((out_r0 + out_r1) == '0))
    else $error("first root pair is not symmetric");

  a_inf_empty: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_status == ST_INF) |-> (out_count == 3'd0 && out_r0 == '0))
    else $error("infinite case carries roots");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s0_v)
    else $error("accepted beat not held in input register");
`endif

endmodule

[rtl/core/brs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// brs_sqrt_cell
// One digit step of a restoring square root, registered.
// ----------------------------------------------------------------------------
module brs_sqrt_cell #(
  parameter int K  = 33,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*K-1:0]  in_rad,
  input  logic [K+1:0]    in_rem,
  input  logic [K-1:0]    in_root,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [2*K-1:0]  out_rad,
  output logic [K+1:0]    out_rem,
  output logic [K-1:0]    out_root,
  output logic [PW-1:0]   out_pay
);

  logic [K+1:0] rem_sh;
  logic [K+1:0] trial;
  logic [K+1:0] rem_sub;
  logic         ge;

  assign rem_sh  = {in_rem[K-1:0], in_rad[2*K-1 -: 2]};
  assign trial   = {in_root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[2*K-3:0], 2'b00};
      out_rem  <= ge ? rem_sub : rem_sh;
      out_root <= {in_root[K-2:0], ge};
      out_pay  <= in_pay;
    end
  end

endmodule

[rtl/core/brs_div_cell.sv]
// ----------------------------------------------------------------------------
// brs_div_cell
// One quotient bit of a restoring unsigned division, registered.
// ----------------------------------------------------------------------------
module brs_div_cell #(
  parameter int NW = 49,
  parameter int DW = 32,
  parameter int PW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_nq,
  input  logic [DW-1:0]  in_rem,
  input  logic [DW-1:0]  in_div,
  input  logic [PW-1:0]  in_pay,
  output logic           out_valid,
  output logic [NW-1:0]  out_nq,
  output logic [DW-1:0]  out_rem,
  output logic [DW-1:0]  out_div,
  output logic [PW-1:0]  out_pay
);

  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        ge;

  assign rem_sh  = {in_rem, in_nq[NW-1]};
  assign ge      = (rem_sh >= {1'b0, in_div});
  assign rem_sub = rem_sh - {1'b0, in_div};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nq  <= {in_nq[NW-2:0], ge};
      out_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      out_div <= in_div;
      out_pay <= in_pay;
    end
  end

endmodule
